@@ src/kpr_pkg.sv @@
// Shared types and constants for the k-permutation rank block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package kpr_pkg;

  // Largest value count supported; used-value map is this wide
  localparam int MAX_VALUES = 16;
  localparam int USED_W     = MAX_VALUES;
  localparam int CNT_W      = $clog2(MAX_VALUES + 1);

  // Fixed field widths
  localparam int ELEM_W  = 4;
  localparam int RANK_W  = 45;
  localparam int CFG_W   = 5;
  localparam int POS_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int FACT_W  = 5;
  localparam int PROD_W  = RANK_W + FACT_W;
  localparam int TOP_W   = 7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALUE_COUNT = 1'b0,
    REG_ARR_LENGTH  = 1'b1
  } cfg_reg_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_COMMIT
  } kpr_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture element, compute count and suffix setup
    logic step;     // one multiply of the suffix product
    logic commit;   // fold product into the running rank
  } kpr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mul_done; // no suffix factors left
    logic last;     // element completes the arrangement
    logic out_busy; // result register full and not drained this cycle
  } kpr_sts_t;

endpackage
`default_nettype wire

@@ src/kpr_ctrl.sv @@
// Controller state machine for the k-permutation rank block.
// Depends on kpr_pkg; drives kpr_datapath through kpr_cmd_t / kpr_sts_t.
`default_nettype none
module kpr_ctrl import kpr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire kpr_sts_t sts,
  output kpr_cmd_t      cmd
);

  kpr_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.mul_done) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_COMMIT: begin
        // hold while a finished result still waits and this one would replace it
        if (!(sts.last && sts.out_busy)) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && sts.last) |-> !sts.out_busy)
    else $error("result register overwritten");

  // Multiplier is not stepped once the factor count is exhausted
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !sts.mul_done)
    else $error("suffix product stepped past its last factor");

  // A transaction is accepted only with no element in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (!cmd.load && (cmd.step || state_r == S_MUL)))
    else $error("second element accepted while one is in flight");

endmodule
`default_nettype wire

@@ src/kpr_datapath.sv @@
// Datapath for the k-permutation rank block: config registers, run state,
// shared suffix multiplier and result register. Depends on kpr_pkg.
`default_nettype none
module kpr_datapath import kpr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic [ELEM_W-1:0]    in_element,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic [RANK_W-1:0]         out_rank,
  output logic                      out_invalid,
  input  wire kpr_cmd_t             cmd,
  output kpr_sts_t                  sts
);

  // Configuration
  logic [CFG_W-1:0] value_count_r, arr_len_r;
  // Run state
  logic [USED_W-1:0] used_r;
  logic [POS_W-1:0]  pos_r;
  logic [RANK_W-1:0] rank_r;
  logic              err_r;
  // Per-element working registers
  logic [ELEM_W-1:0] elem_r;
  logic              bad_r, last_r;
  logic [RANK_W-1:0] acc_r;
  logic signed [TOP_W-1:0] top_r;
  logic [POS_W-1:0]  left_r;
  // Result register
  logic              out_valid_r, out_invalid_r;
  logic [RANK_W-1:0] out_rank_r;

  logic [CFG_W-1:0]  n_eff, k_eff;
  logic [USED_W-1:0] low_mask, free_below;
  logic [CNT_W-1:0]  below;
  logic              bad_now, last_now;
  logic signed [TOP_W-1:0] top_now, terms_now;
  logic [PROD_W-1:0] prod;
  logic [RANK_W-1:0] rank_sum_new;
  logic              err_new;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_count_r <= CFG_W'(MAX_VALUES);
      arr_len_r     <= CFG_W'(MAX_VALUES);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VALUE_COUNT: value_count_r <= cfg_wdata;
        REG_ARR_LENGTH:  arr_len_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective n and k: zero taken as one, saturate at the upper bound
  always_comb begin
    if (value_count_r == '0) begin
      n_eff = CFG_W'(1);
    end else if (value_count_r > CFG_W'(MAX_VALUES)) begin
      n_eff = CFG_W'(MAX_VALUES);
    end else begin
      n_eff = value_count_r;
    end
    if (arr_len_r == '0) begin
      k_eff = CFG_W'(1);
    end else if (arr_len_r > n_eff) begin
      k_eff = n_eff;
    end else begin
      k_eff = arr_len_r;
    end
  end

  // Count unused values below the incoming element
  always_comb begin
    low_mask   = (USED_W'(1) << in_element) - USED_W'(1);
    free_below = ~used_r & low_mask;
    below      = '0;
    for (int v = 0; v < USED_W; v++) begin
      below = below + CNT_W'(free_below[v]);
    end
  end

  // Element checks and suffix setup
  always_comb begin
    bad_now   = ({1'b0, in_element} >= n_eff) || used_r[in_element];
    top_now   = $signed(TOP_W'(n_eff)) - $signed(TOP_W'(pos_r)) - TOP_W'(1);
    terms_now = $signed(TOP_W'(k_eff)) - $signed(TOP_W'(pos_r)) - TOP_W'(1);
    last_now  = (TOP_W'(pos_r) + TOP_W'(1)) >= TOP_W'(k_eff);
  end

  // Shared multiplier: running product times the next falling factor
  assign prod = acc_r * PROD_W'(top_r[FACT_W-1:0]);

  // Working registers: load, then one factor per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      elem_r <= in_element;
      bad_r  <= bad_now;
      last_r <= last_now;
      acc_r  <= RANK_W'(below);
      top_r  <= top_now;
      left_r <= (terms_now > 0) ? terms_now[POS_W-1:0] : '0;
    end else if (cmd.step) begin
      acc_r  <= (top_r < 1) ? '0 : prod[RANK_W-1:0];
      top_r  <= top_r - TOP_W'(1);
      left_r <= left_r - POS_W'(1);
    end
  end

  // Folded rank and error for the element being committed
  assign rank_sum_new = bad_r ? rank_r : rank_r + acc_r;
  assign err_new      = err_r | bad_r;

  // Run state: advance on commit, clear after the last element
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      pos_r  <= '0;
      rank_r <= '0;
      err_r  <= 1'b0;
    end else if (cmd.commit) begin
      if (last_r) begin
        used_r <= '0;
        pos_r  <= '0;
        rank_r <= '0;
        err_r  <= 1'b0;
      end else begin
        if (!bad_r) begin
          used_r <= used_r | (USED_W'(1) << elem_r);
        end
        pos_r  <= pos_r + POS_W'(1);
        rank_r <= rank_sum_new;
        err_r  <= err_new;
      end
    end
  end

  // Result register: load on the last commit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && last_r) begin
      out_rank_r    <= err_new ? '0 : rank_sum_new;
      out_invalid_r <= err_new;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_rank    = out_rank_r;
  assign out_invalid = out_invalid_r;

  assign sts.mul_done = (left_r == '0);
  assign sts.last     = last_r;
  assign sts.out_busy = out_valid_r && out_stall;

endmodule
`default_nettype wire

@@ src/k_permutation_rank.sv @@
// Top level of the k-permutation rank block.
// Depends on kpr_pkg, kpr_ctrl and kpr_datapath.
`default_nettype none
// Elements of a size-k arrangement of 0..n-1 arrive one per input transaction,
// first element first; after the k-th element one result transaction carries
// the 0-based lexicographic rank, or rank 0 with out_invalid set if any
// element was out of range or repeated. An element at position i is handled
// in order: capture it and count the unused values below it, multiply once
// per factor of the suffix count on a single shared 45 x 5 multiplier, see
// the count exhausted, then fold the product into the rank. One element is
// in flight at a time. A finished result waits in an output register, so the
// next arrangement can start while it is held; the last element of that one
// waits until the earlier result is taken. Write n (index 0) and k (index 1)
// only while idle; both reset to 16.
module k_permutation_rank import kpr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ELEM_W-1:0]    in_element,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [RANK_W-1:0]         out_rank,
  output logic                      out_invalid
);

  kpr_cmd_t cmd;
  kpr_sts_t sts;

  // Sequencer
  kpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Rank arithmetic and storage
  kpr_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_element  (in_element),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_rank    (out_rank),
    .out_invalid (out_invalid),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
`default_nettype wire
